// ===== sv/mpi_pkg.sv =====
// Shared types and constants for the mutex priority inheritance unit.
package mpi_pkg;

	localparam int TASKS_DEFAULT = 16;
	localparam int TID_W         = 4;
	localparam int PRIO_W        = 8;
	localparam int MASK_W        = 16;
	localparam int IN_DATA_W     = 16;
	localparam int OUT_DATA_W    = 40;

	typedef enum logic {
		MODE_LOCK   = 1'b0,
		MODE_UNLOCK = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [TID_W-1:0]  task_id;
		logic [PRIO_W-1:0] task_priority;
	} req_t;

	typedef struct packed {
		logic [MASK_W-1:0] wake_mask;
		logic [PRIO_W-1:0] restore_priority;
		logic              restore_valid;
		logic [PRIO_W-1:0] boost_priority;
		logic [TID_W-1:0]  boost_task;
		logic              boost_valid;
		logic              blocked;
		logic              granted;
	} rsp_t;

endpackage

// ===== sv/mpi_core.sv =====
// Mutex state, lock and unlock decision logic, and priority inheritance.
module mpi_core
	import mpi_pkg::*;
#(
	parameter int TASKS = TASKS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  logic inherit_enable,
	input  req_t req,
	output rsp_t rsp
);

	localparam int WAIT_W = (TASKS < MASK_W) ? TASKS : MASK_W;

	logic              locked_q;
	logic [TID_W-1:0]  owner_q;
	logic [PRIO_W-1:0] owner_prio_q;
	logic [PRIO_W-1:0] saved_prio_q;
	logic [WAIT_W-1:0] waiter_q;

	logic              locked_d;
	logic [TID_W-1:0]  owner_d;
	logic [PRIO_W-1:0] owner_prio_d;
	logic [PRIO_W-1:0] saved_prio_d;
	logic [WAIT_W-1:0] waiter_d;
	logic [WAIT_W-1:0] set_vec;

	always_comb begin
		for (int i = 0; i < WAIT_W; i++) begin
			set_vec[i] = (req.task_id == TID_W'(i));
		end
	end

	always_comb begin
		rsp          = '0;
		locked_d     = locked_q;
		owner_d      = owner_q;
		owner_prio_d = owner_prio_q;
		saved_prio_d = saved_prio_q;
		waiter_d     = waiter_q;
		unique case (req.mode)
			MODE_LOCK: begin
				if (!locked_q) begin
					locked_d     = 1'b1;
					owner_d      = req.task_id;
					owner_prio_d = req.task_priority;
					saved_prio_d = req.task_priority;
					rsp.granted  = 1'b1;
				end else begin
					if (inherit_enable && (req.task_priority > owner_prio_q)) begin
						owner_prio_d       = req.task_priority;
						rsp.boost_valid    = 1'b1;
						rsp.boost_task     = owner_q;
						rsp.boost_priority = req.task_priority;
					end
					waiter_d    = waiter_q | set_vec;
					rsp.blocked = 1'b1;
				end
			end
			MODE_UNLOCK: begin
				if (locked_q) begin
					rsp.restore_valid    = 1'b1;
					rsp.restore_priority = saved_prio_q;
					rsp.wake_mask        = MASK_W'(waiter_q);
					locked_d             = 1'b0;
					owner_d              = '0;
					owner_prio_d         = '0;
					waiter_d             = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q     <= 1'b0;
			owner_q      <= '0;
			owner_prio_q <= '0;
			saved_prio_q <= '0;
			waiter_q     <= '0;
		end else if (fire) begin
			locked_q     <= locked_d;
			owner_q      <= owner_d;
			owner_prio_q <= owner_prio_d;
			saved_prio_q <= saved_prio_d;
			waiter_q     <= waiter_d;
		end
	end

	a_free_no_waiters: assert property (@(posedge clk) disable iff (!arst_n)
		!locked_q |-> (waiter_q == '0))
		else $error("waiters recorded on a free mutex");

	a_grant_locks: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rsp.granted) |=> locked_q)
		else $error("grant did not lock the mutex");

	a_unlock_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (req.mode == MODE_UNLOCK)) |=> (!locked_q && (waiter_q == '0)))
		else $error("unlock left the mutex held or waiters pending");

	a_boost_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rsp.boost_valid) |=> (owner_prio_q == $past(req.task_priority)))
		else $error("boost not recorded as owner priority");

	a_boost_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.boost_valid |-> (rsp.blocked && locked_q))
		else $error("boost reported without a blocked caller on a held mutex");

endmodule

// ===== sv/mutex_priority_inheritance_unit.sv =====
// Top level of the mutex priority inheritance unit: stream ports, staging and config register.
//
// Channel  Direction  Signals                       Transaction
// s_*      in         s_tvalid s_tready s_tdata     one lock or unlock request
//                     s_tuser
// m_*      out        m_tvalid m_tready m_tdata     one result per request
// cfg_*    in         cfg_valid cfg_ready cfg_data  write of inherit_enable
//
// A request passes through the input register, then the result register; the mutex state updates
// as it moves to the result register. One request is taken per cycle unless the result stalls.
// Reset frees the mutex, clears the waiters and sets inherit_enable.
// A stalled result holds the result register; the input register then holds its request.
// cfg_ready is always high.
module mutex_priority_inheritance_unit
	import mpi_pkg::*;
#(
	parameter int TASKS = TASKS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [3:0] task_id, [11:4] task_priority, [15:12] unused
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [0] mode
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] granted, [1] blocked, [2] boost_valid, [6:3] boost_task,
	// [14:7] boost_priority, [15] restore_valid, [23:16] restore_priority,
	// [39:24] wake_mask
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data
);

	logic inherit_q;
	logic valid_s1;
	req_t req_s1;
	logic valid_s2;
	rsp_t rsp_s2;
	rsp_t rsp;
	logic advance;

	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inherit_q <= 1'b1;
		end else if (cfg_valid) begin
			inherit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.mode          <= mode_t'(s_tuser);
			req_s1.task_id       <= s_tdata[TID_W-1:0];
			req_s1.task_priority <= s_tdata[TID_W+PRIO_W-1:TID_W];
		end
	end

	mpi_core #(
		.TASKS(TASKS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (advance),
		.inherit_enable(inherit_q),
		.req           (req_s1),
		.rsp           (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_DATA_W'(rsp_s2);

endmodule
